// ----- hdl/itp_pkg.sv -----
package itp_pkg;

  // Operator codes as they are kept on the operator stack.
  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_POW   = 3'd5
  } op_code_e;

  // Kind of a result transfer.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Class of an accepted input character.
  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_UNKNOWN,
    CLS_END
  } sym_class_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOP,
    S_TOP,
    S_DONE
  } state_e;

  // ASCII characters the converter recognizes.
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_MUL   = 8'h2a;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_DIV   = 8'h2f;
  localparam logic [7:0] CHAR_POW   = 8'h5e;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7a;

  // Highest precedence; operators at this level associate to the right.
  localparam logic [1:0] PREC_RIGHT = 2'd3;

  // Character that a stacked operator code prints as.
  function automatic logic [7:0] code_char(logic [2:0] code);
    logic [7:0] ch;
    case (code)
      OP_OPEN:  ch = CHAR_OPEN;
      OP_PLUS:  ch = CHAR_PLUS;
      OP_MINUS: ch = CHAR_MINUS;
      OP_MUL:   ch = CHAR_MUL;
      OP_DIV:   ch = CHAR_DIV;
      OP_POW:   ch = CHAR_POW;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Binding strength of an operator code; '(' is lowest.
  function automatic logic [1:0] code_prec(logic [2:0] code);
    logic [1:0] p;
    case (code)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      OP_POW:            p = PREC_RIGHT;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/infix_to_postfix_converter_top.sv -----
// Infix to postfix converter. Send one ASCII character per input transfer;
// tlast high marks the end of the expression (tdata is then ignored). Letters
// come straight out, operators and parentheses are reordered through an
// operator stack of STACK_DEPTH entries held in a small memory, and the end
// transfer flushes the stack and yields an end marker. Each result carries a
// kind in tuser (character, end, error) and tlast on the last result caused by
// one input. The block takes one input at a time and is busy until it is done
// with it: each stack entry examined costs a registered memory read of the
// stack top (S_LOOP) and then a step that acts on it (S_TOP). An item ends
// when it runs the stack empty or when it stops at an entry (an operator that
// stays below the new one, a ')' that meets its '(', or a push onto a full
// stack). A full output stage that is not drained stalls the sequencer.
module infix_to_postfix_converter_top
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,   // end_of_expr
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  state_e     state_q, state_d;
  sym_class_e cls_q, cls_in;
  logic [2:0] code_q, code_in;
  logic [7:0] sym_q;
  logic [CW-1:0] count_q;

  logic [2:0] mem [STACK_DEPTH];
  logic [2:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic [2:0] push_code;

  logic       pend_valid_q;
  logic [7:0] pend_sym_q;
  kind_e      pend_kind_q;

  logic       m_valid_q;
  logic [7:0] m_data_q;
  kind_e      m_kind_q;
  logic       m_last_q;

  logic       in_xfer;
  logic       out_free;
  logic       emit_go;
  logic       step_ok;
  logic       flush_go;
  logic       load_out;
  logic       cnt_zero;
  logic       full;
  logic       top_is_open;
  logic       pop_ok;
  logic [1:0] top_prec;
  logic [1:0] in_prec;

  logic       emit_req;
  logic [7:0] emit_sym;
  kind_e      emit_kind;
  logic       cnt_dec;
  logic       cnt_clr;
  logic       push_we;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign emit_go       = !pend_valid_q || out_free;
  assign step_ok       = !emit_req || emit_go;
  assign flush_go      = (state_q == S_DONE) && pend_valid_q && out_free;
  assign load_out      = flush_go || (emit_req && emit_go && pend_valid_q);

  assign cnt_zero    = (count_q == '0);
  assign full        = (count_q == CW'(STACK_DEPTH));
  assign top_is_open = (rd_q == OP_OPEN);
  assign top_prec    = code_prec(rd_q);
  assign in_prec     = code_prec(code_q);
  assign pop_ok      = !top_is_open &&
                       ((top_prec > in_prec) ||
                        ((top_prec == in_prec) && (in_prec != PREC_RIGHT)));

  // Classify the incoming character.
  always_comb begin
    code_in = OP_OPEN;
    if (s_axis_tlast) begin
      cls_in = CLS_END;
    end else if (s_axis_tdata >= CHAR_A && s_axis_tdata <= CHAR_Z) begin
      cls_in = CLS_LETTER;
    end else if (s_axis_tdata == CHAR_OPEN) begin
      cls_in = CLS_OPEN;
    end else if (s_axis_tdata == CHAR_CLOSE) begin
      cls_in = CLS_CLOSE;
    end else if (s_axis_tdata == CHAR_PLUS) begin
      cls_in  = CLS_OP;
      code_in = OP_PLUS;
    end else if (s_axis_tdata == CHAR_MINUS) begin
      cls_in  = CLS_OP;
      code_in = OP_MINUS;
    end else if (s_axis_tdata == CHAR_MUL) begin
      cls_in  = CLS_OP;
      code_in = OP_MUL;
    end else if (s_axis_tdata == CHAR_DIV) begin
      cls_in  = CLS_OP;
      code_in = OP_DIV;
    end else if (s_axis_tdata == CHAR_POW) begin
      cls_in  = CLS_OP;
      code_in = OP_POW;
    end else begin
      cls_in = CLS_UNKNOWN;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_LOOP;
      end
      S_LOOP: begin
        if (step_ok) begin
          if (!cnt_zero &&
              (cls_q == CLS_END || cls_q == CLS_CLOSE || cls_q == CLS_OP)) begin
            state_d = S_TOP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_TOP: begin
        if (step_ok) begin
          priority case (cls_q)
            CLS_END:   state_d = S_LOOP;
            CLS_CLOSE: state_d = top_is_open ? S_DONE : S_LOOP;
            CLS_OP:    state_d = pop_ok ? S_LOOP : S_DONE;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (!pend_valid_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer actions: results, stack pointer moves and pushes.
  always_comb begin
    emit_req  = 1'b0;
    emit_sym  = 8'h00;
    emit_kind = KIND_CHAR;
    cnt_dec   = 1'b0;
    cnt_clr   = 1'b0;
    push_we   = 1'b0;
    unique case (state_q)
      S_LOOP: begin
        priority case (cls_q)
          CLS_END: begin
            if (cnt_zero) begin
              emit_req  = 1'b1;
              emit_kind = KIND_END;
            end
          end
          CLS_LETTER: begin
            emit_req = 1'b1;
            emit_sym = sym_q;
          end
          CLS_OPEN: begin
            if (full) begin
              emit_req  = 1'b1;
              emit_kind = KIND_ERROR;
              cnt_clr   = 1'b1;
            end else begin
              push_we = 1'b1;
            end
          end
          CLS_CLOSE: begin
            if (cnt_zero) begin
              emit_req  = 1'b1;
              emit_kind = KIND_ERROR;
            end
          end
          CLS_OP: begin
            if (cnt_zero) push_we = 1'b1;
          end
          default: begin
            emit_req  = 1'b1;
            emit_kind = KIND_ERROR;
            cnt_clr   = 1'b1;
          end
        endcase
      end
      S_TOP: begin
        priority case (cls_q)
          CLS_END: begin
            emit_req = 1'b1;
            emit_sym = code_char(rd_q);
            cnt_dec  = 1'b1;
          end
          CLS_CLOSE: begin
            cnt_dec = 1'b1;
            if (!top_is_open) begin
              emit_req = 1'b1;
              emit_sym = code_char(rd_q);
            end
          end
          CLS_OP: begin
            if (pop_ok) begin
              emit_req = 1'b1;
              emit_sym = code_char(rd_q);
              cnt_dec  = 1'b1;
            end else if (full) begin
              emit_req  = 1'b1;
              emit_kind = KIND_ERROR;
              cnt_clr   = 1'b1;
            end else begin
              push_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Control registers: state, input class and stack pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cls_q   <= CLS_END;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) cls_q <= cls_in;
      if (step_ok) begin
        if (cnt_clr) begin
          count_q <= '0;
        end else if (cnt_dec) begin
          count_q <= count_q - CW'(1);
        end else if (push_we) begin
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  // Captured input character.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sym_q  <= s_axis_tdata;
      code_q <= code_in;
    end
  end

  // Operator stack memory with a registered read of the current top.
  assign rd_addr   = AW'(count_q - CW'(1));
  assign push_code = (cls_q == CLS_OPEN) ? OP_OPEN : code_q;

  always_ff @(posedge clk_i) begin
    if (push_we) mem[count_q[AW-1:0]] <= push_code;
    rd_q <= mem[rd_addr];
  end

  // One result is held back until it is known whether it is the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (emit_req && emit_go) begin
      pend_valid_q <= 1'b1;
    end else if (flush_go) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req && emit_go) begin
      pend_sym_q  <= emit_sym;
      pend_kind_q <= emit_kind;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= pend_sym_q;
      m_kind_q <= pend_kind_q;
      m_last_q <= flush_go;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- hdl/itp_checker.sv -----
module itp_checker
  import itp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only the three defined kinds appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_CHAR || m_axis_tuser == KIND_END ||
                       m_axis_tuser == KIND_ERROR))
    else $error("undefined result kind");

  // End and error markers carry no character and always close an input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_CHAR) |->
      (m_axis_tdata == 8'h00) && m_axis_tlast)
    else $error("marker result malformed");

  // When a new input may be taken, no unfinished result run is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("input taken before previous result run completed");

  // An end-of-expression transfer takes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready right after end transfer");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
